### rtl/mepp_pkg.sv
// ----------------------------------------------------------------------------
// mepp_pkg: shared types and constants of the equal-power panner
// Operation and register codes, the work-queue entry and the fixed-point
// coefficients of the quarter-cosine series.
// ----------------------------------------------------------------------------
package mepp_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int QUEUE_DEPTH      = 2;

  // Channel numbers held in a queue entry; wide enough for channel numbers
  // up to 63.
  localparam int IDX_W = 6;

  // Operation codes of an input word.
  localparam logic [1:0] OP_POSITION   = 2'd0;
  localparam logic [1:0] OP_SET_ADJUST = 2'd1;
  localparam logic [1:0] OP_REPEAT     = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_MASTER_GAIN   = 1'b1;

  // Gains are Q4.12 (pan gains Q12, at most 1.0).
  localparam int          GAIN_W      = 16;
  localparam int          PAN_W       = 13;
  localparam logic [PAN_W-1:0]  PAN_ONE    = 13'd4096;
  localparam logic [GAIN_W-1:0] ADJ_RESET  = 16'd4096;
  localparam logic [4:0]        COUNT_RESET = 5'd2;
  localparam logic [GAIN_W-1:0] MASTER_RESET = 16'd4096;

  // Cosine series in Q24, evaluated by Horner's rule on a shared multiplier.
  localparam int ACC_W  = 27;
  localparam int X_W    = 26;
  localparam int PROD_W = ACC_W + X_W;
  localparam logic signed [ACC_W-1:0] COS_ONE = 27'sd16777216;
  localparam logic signed [ACC_W-1:0] COS_A2  = 27'sd20698061;
  localparam logic signed [ACC_W-1:0] COS_A4  = 27'sd4255868;
  localparam logic signed [ACC_W-1:0] COS_A6  = 27'sd350031;
  localparam logic signed [ACC_W-1:0] COS_A8  = 27'sd15423;

  // One entry of the work queue: either an adjust-table write or a run of
  // results whose only non-zero pan gains sit on channels ch and ch + 1.
  typedef struct packed {
    logic              is_set;
    logic [IDX_W-1:0]  ch;
    logic [PAN_W-1:0]  lo_gain;
    logic [PAN_W-1:0]  hi_gain;
    logic [GAIN_W-1:0] value;
  } entry_t;

  // Divide a Q48 product by 2^24, truncating toward zero.
  function automatic logic signed [ACC_W-1:0] q24_trunc(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] adj;
    adj = (v < 0) ? (v + PROD_W'(24'hFF_FFFF)) : v;
    return ACC_W'(adj >>> 24);
  endfunction

endpackage

### rtl/multichannel_equal_power_panner.sv
// ----------------------------------------------------------------------------
// multichannel_equal_power_panner: equal-power panner over N output channels
// Turns pan positions into one Q4.12 gain per channel in use.
// ----------------------------------------------------------------------------
// Usage. A command word is taken at a clock edge where start is high and busy
// is low. op selects a new position, an adjust-gain write for one channel, or
// a repeat of the last position. A position or repeat word produces one result
// word per channel in use, highest channel first; each result sits on
// out_channel, out_gain and last for exactly one cycle with strobe high, and
// last marks channel 0. The receiver cannot stall, so results are never held.
// Flow. A position that falls between two channels is held in the front end
// while it evaluates both cosine gains on one multiplier; other commands pass
// the front end in the cycle they are accepted. The back end then takes the
// entry from the queue and steps through the channels in turn; each channel's
// result is registered in a_prod and then in the output registers.
// The two-entry queue lets the front end take the next word while the back
// end is still emitting. busy is high while the front end is evaluating or
// the queue is full.
// Reset clears the adjust table to 1.0, forgets the last position (a repeat
// then gives all-zero gains), and sets two channels and a master gain of 1.0.
// Configuration registers (channel_count, master_gain) are written through
// cfg_write, cfg_index and cfg_data and should change only while idle.
// ----------------------------------------------------------------------------
module multichannel_equal_power_panner #(
  parameter int MAX_CHANNELS = mepp_pkg::MAX_CHANNELS_DEF,
  parameter int FRAC_BITS    = mepp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [15:0] position,
  input  logic [3:0]         channel,
  input  logic [15:0]        adjust_value,
  output logic               strobe,
  output logic [3:0]         out_channel,
  output logic [15:0]        out_gain,
  output logic               last
);
  import mepp_pkg::*;

  localparam int NW = $clog2(MAX_CHANNELS + 1);

  logic [4:0]    channel_count;
  logic [15:0]   master_gain;
  logic [NW-1:0] active_n;

  logic          accept;
  logic          front_busy;
  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        pop_entry;
  logic          q_empty;
  logic          q_full;

  // Configuration registers; out-of-range channel counts are clamped in active_n below.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= COUNT_RESET;
      master_gain   <= MASTER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        CFG_MASTER_GAIN:   master_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (channel_count < 5'd2) begin
      active_n = NW'(2);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      active_n = NW'(MAX_CHANNELS);
    end else begin
      active_n = NW'(channel_count);
    end
  end

  // The front end may always push once it has accepted a word, because a
  // word is only taken while the queue has room.
  assign busy   = front_busy || q_full;
  assign accept = start && !busy;

  mepp_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (op),
    .position     (position),
    .channel      (channel),
    .adjust_value (adjust_value),
    .active_n     (active_n),
    .front_busy   (front_busy),
    .push         (push),
    .push_entry   (push_entry)
  );

  mepp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .empty     (q_empty),
    .full      (q_full)
  );

  mepp_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (pop_entry),
    .q_pop       (pop),
    .active_n    (active_n),
    .master_gain (master_gain),
    .strobe      (strobe),
    .out_channel (out_channel),
    .out_gain    (out_gain),
    .last        (last)
  );

`ifndef SYNTHESIS
  // The queue is never written while it is full.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("queue written while full");

  // The final word of a run belongs to channel 0.
  assert property (@(posedge clk) disable iff (rst) (strobe && last) |-> (out_channel == 4'd0))
    else $error("last result not on channel 0");

  // A run is emitted without gaps until its final word.
  assert property (@(posedge clk) disable iff (rst) (strobe && !last) |=> strobe)
    else $error("gap inside a run of results");

  // Within a run the channel number counts down by one each word.
  assert property (@(posedge clk) disable iff (rst)
      (strobe && !last) |=> (out_channel == 4'($past(out_channel) - 4'd1)))
    else $error("channel order broken inside a run");
`endif

endmodule

### rtl/mepp_fifo.sv
// ----------------------------------------------------------------------------
// mepp_fifo: work queue between the front and back ends
// A small first-in first-out store of queue entries with full and empty flags.
// ----------------------------------------------------------------------------
module mepp_fifo #(
  parameter int DEPTH = mepp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mepp_pkg::entry_t push_data,
  input  logic            pop,
  output mepp_pkg::entry_t pop_data,
  output logic            empty,
  output logic            full
);
  import mepp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/mepp_front.sv
// ----------------------------------------------------------------------------
// mepp_front: command decode and pan-gain evaluation
// Classifies each accepted word, keeps the last position, and evaluates the
// two quarter-cosine gains of a mid-range position on one shared multiplier.
// ----------------------------------------------------------------------------
module mepp_front #(
  parameter int MAX_CHANNELS = mepp_pkg::MAX_CHANNELS_DEF,
  parameter int FRAC_BITS    = mepp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [1:0]                         op,
  input  logic signed [15:0]                 position,
  input  logic [3:0]                         channel,
  input  logic [15:0]                        adjust_value,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]  active_n,
  output logic                               front_busy,
  output logic                               push,
  output mepp_pkg::entry_t                   push_entry
);
  import mepp_pkg::*;

  localparam int NW    = $clog2(MAX_CHANNELS + 1);
  localparam int LIM_W = NW + FRAC_BITS + 1;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_CALC = 1'b1;

  localparam logic [2:0] STEP_SQUARE = 3'd0;
  localparam logic [2:0] STEP_LEAD   = 3'd1;
  localparam logic [2:0] STEP_DONE   = 3'd5;

  logic                      state;
  logic [15:0]               last_position;
  logic                      position_seen;
  logic [PAN_W-1:0]          phase;
  logic                      second;
  logic [2:0]                step;
  logic [IDX_W-1:0]          lo_ch;
  logic [PAN_W-1:0]          lo_gain;
  logic [X_W-1:0]            x_sq;
  logic signed [PROD_W-1:0]  prod;

  // Decode of the word at the input.
  logic signed [15:0]        pos_sel;
  logic                      seen_eff;
  logic signed [LIM_W-1:0]   limit;
  logic [15:0]               pos_int;
  logic [PAN_W-1:0]          phase_in;
  logic                      start_calc;
  entry_t                    direct_entry;
  logic                      direct_push;

  // Shared multiplier and series arithmetic.
  logic [PAN_W-1:0]          p_cur;
  logic signed [ACC_W-1:0]   mul_a;
  logic signed [X_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_c;
  logic [PAN_W-1:0]          cos_q12;

  function automatic logic signed [ACC_W-1:0] series_coef(input logic [2:0] s);
    case (s)
      3'd2:    return -COS_A6;
      3'd3:    return COS_A4;
      3'd4:    return -COS_A2;
      default: return COS_ONE;
    endcase
  endfunction

  assign front_busy = (state == F_CALC);

  always_comb begin
    pos_sel      = (op == OP_POSITION) ? position : $signed(last_position);
    seen_eff     = (op == OP_POSITION) || position_seen;
    limit        = $signed(LIM_W'(active_n - NW'(1)) << FRAC_BITS);
    pos_int      = 16'($unsigned(pos_sel) >> FRAC_BITS);
    phase_in     = PAN_W'(pos_sel[FRAC_BITS-1:0]) << (12 - FRAC_BITS);
    start_calc   = 1'b0;
    direct_push  = 1'b0;
    direct_entry = '0;
    case (op)
      OP_POSITION, OP_REPEAT: begin
        if (!seen_eff) begin
          direct_push = 1'b1;
        end else if (pos_sel <= 16'sd0) begin
          direct_push          = 1'b1;
          direct_entry.lo_gain = PAN_ONE;
        end else if (pos_sel >= limit) begin
          direct_push          = 1'b1;
          direct_entry.ch      = IDX_W'(active_n - NW'(1));
          direct_entry.lo_gain = PAN_ONE;
        end else begin
          start_calc = 1'b1;
        end
      end
      OP_SET_ADJUST: begin
        if ((adjust_value != 16'd0) && (32'(channel) < 32'(active_n))) begin
          direct_push         = 1'b1;
          direct_entry.is_set = 1'b1;
          direct_entry.ch     = IDX_W'(channel);
          direct_entry.value  = adjust_value;
        end
      end
      default: ;
    endcase
  end

  // Horner evaluation: square the phase, then four multiply-accumulate steps.
  always_comb begin
    p_cur = second ? (PAN_ONE - phase) : phase;
    case (step)
      STEP_SQUARE: begin
        mul_a = $signed(ACC_W'(p_cur));
        mul_b = $signed(X_W'(p_cur));
      end
      STEP_LEAD: begin
        mul_a = COS_A8;
        mul_b = $signed(x_sq);
      end
      default: begin
        mul_a = series_coef(step) + q24_trunc(prod);
        mul_b = $signed(x_sq);
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    acc   = COS_ONE + q24_trunc(prod);
    if (acc < 0) begin
      acc_c = '0;
    end else if (acc > COS_ONE) begin
      acc_c = COS_ONE;
    end else begin
      acc_c = acc;
    end
    cos_q12 = PAN_W'((acc_c + ACC_W'(2048)) >>> 12);
    if (cos_q12 > PAN_ONE) begin
      cos_q12 = PAN_ONE;
    end
  end

  always_comb begin
    push       = 1'b0;
    push_entry = direct_entry;
    if (state == F_IDLE) begin
      push = accept && direct_push;
    end else if ((step == STEP_DONE) && second) begin
      push               = 1'b1;
      push_entry         = '0;
      push_entry.ch      = lo_ch;
      push_entry.lo_gain = lo_gain;
      push_entry.hi_gain = cos_q12;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      last_position <= '0;
      position_seen <= 1'b0;
    end else begin
      if (state == F_IDLE) begin
        if (accept) begin
          if (op == OP_POSITION) begin
            last_position <= position;
            position_seen <= 1'b1;
          end
          if (start_calc) begin
            state <= F_CALC;
          end
        end
      end else if ((step == STEP_DONE) && second) begin
        state <= F_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      phase  <= phase_in;
      lo_ch  <= IDX_W'(pos_int);
      step   <= STEP_SQUARE;
      second <= 1'b0;
    end else begin
      if (step == STEP_SQUARE) begin
        x_sq <= X_W'(mul_p);
      end else begin
        prod <= mul_p;
      end
      if (step == STEP_DONE) begin
        step    <= STEP_SQUARE;
        second  <= 1'b1;
        lo_gain <= cos_q12;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

endmodule

### rtl/mepp_back.sv
// ----------------------------------------------------------------------------
// mepp_back: adjust table and result sequencer
// Takes queue entries, writes adjust gains, and steps through the channels
// from the highest down, forming master * pan * adjust for each one.
// ----------------------------------------------------------------------------
module mepp_back #(
  parameter int MAX_CHANNELS = mepp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  mepp_pkg::entry_t                   q_data,
  output logic                               q_pop,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]  active_n,
  input  logic [15:0]                        master_gain,
  output logic                               strobe,
  output logic [3:0]                         out_channel,
  output logic [15:0]                        out_gain,
  output logic                               last
);
  import mepp_pkg::*;

  localparam int NW      = $clog2(MAX_CHANNELS + 1);
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int PROD1_W = GAIN_W + PAN_W;
  localparam int PROD2_W = PROD1_W + GAIN_W;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic                 state;
  logic [CH_W-1:0]      cnt;
  entry_t               cur;
  logic [PAN_W-1:0]     pan;

  logic [GAIN_W-1:0]    adj_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] adj_valid;
  logic [GAIN_W-1:0]    adj_rd;
  logic                 adj_hit;

  logic                 a_valid;
  logic [CH_W-1:0]      a_ch;
  logic [PROD1_W-1:0]   a_prod;
  logic [GAIN_W-1:0]    adj_eff;
  logic [PROD2_W-1:0]   full_prod;
  logic [PROD2_W-1:0]   rounded;

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    if (IDX_W'(cnt) == cur.ch) begin
      pan = cur.lo_gain;
    end else if (IDX_W'(cnt) == cur.ch + IDX_W'(1)) begin
      pan = cur.hi_gain;
    end else begin
      pan = '0;
    end
    adj_eff   = adj_hit ? adj_rd : ADJ_RESET;
    full_prod = PROD2_W'(a_prod) * PROD2_W'(adj_eff) + PROD2_W'(24'h80_0000);
    rounded   = full_prod >> 24;
  end

  // Adjust table: written by set entries, read once per channel of a run.
  always_ff @(posedge clk) begin
    if (q_pop && q_data.is_set) begin
      adj_mem[q_data.ch[CH_W-1:0]] <= q_data.value;
    end
    adj_rd <= adj_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid <= '0;
      adj_hit   <= 1'b0;
    end else begin
      if (q_pop && q_data.is_set) begin
        adj_valid[q_data.ch[CH_W-1:0]] <= 1'b1;
      end
      adj_hit <= adj_valid[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      cnt     <= '0;
      a_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      a_valid <= (state == B_RUN);
      strobe  <= a_valid;
      if (state == B_IDLE) begin
        if (q_pop && !q_data.is_set) begin
          state <= B_RUN;
          cnt   <= CH_W'(active_n - NW'(1));
        end
      end else begin
        if (cnt == '0) begin
          state <= B_IDLE;
        end else begin
          cnt <= cnt - CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    a_ch        <= cnt;
    a_prod      <= PROD1_W'(master_gain) * PROD1_W'(pan);
    out_channel <= 4'(a_ch);
    last        <= (a_ch == '0);
    out_gain    <= (rounded > PROD2_W'(16'hFFFF)) ? 16'hFFFF : GAIN_W'(rounded);
  end

endmodule
